FILE: hw/rtl/dpdt_pkg.sv
// Shared types and constants for the dual prescaled down-counter timer.
package dpdt_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned CTRL_W = 8;
    localparam int unsigned PRE_W  = 8;
    localparam int unsigned OFF_W  = 8;
    localparam int unsigned ACT_W  = 2;
    localparam int unsigned HALF_W = 16;

    typedef enum logic [ACT_W-1:0] {
        ACT_READ  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_TICK  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    // Register index: offset bits 4:2 within a channel window
    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_LOAD    = 3'd0;
    localparam t_reg_idx REG_VALUE   = 3'd1;
    localparam t_reg_idx REG_CONTROL = 3'd2;
    localparam t_reg_idx REG_INTCLR  = 3'd3;
    localparam t_reg_idx REG_RIS     = 3'd4;
    localparam t_reg_idx REG_MIS     = 3'd5;
    localparam t_reg_idx REG_BGLOAD  = 3'd6;
    localparam t_reg_idx REG_SPARE   = 3'd7;

    // Control register bits
    localparam int unsigned CTL_ENABLE   = 7;
    localparam int unsigned CTL_PERIODIC = 6;
    localparam int unsigned CTL_INTEN    = 5;
    localparam int unsigned CTL_PRE_HI   = 3;
    localparam int unsigned CTL_PRE_LO   = 2;
    localparam int unsigned CTL_SIZE32   = 1;
    localparam int unsigned CTL_ONESHOT  = 0;

    localparam logic [1:0] PRE_DIV1   = 2'd0;
    localparam logic [1:0] PRE_DIV16  = 2'd1;

    localparam logic [OFF_W-1:0]  IGNORED_OFFSET = 8'h80;
    localparam logic [DATA_W-1:0] COUNT_RESET    = 32'hFFFF_FFFF;
    localparam logic [CTRL_W-1:0] CTRL_RESET     = 8'h20;

    typedef struct packed {
        logic              wr_en;
        logic              tick;
        t_reg_idx          idx;
        logic [DATA_W-1:0] wdata;
    } t_chan_cmd;

    typedef struct packed {
        logic [DATA_W-1:0] rdata;
        logic              irq;
    } t_chan_stat;

endpackage

FILE: hw/rtl/dpdt_if.sv
// Valid/ready channel interfaces for timer command and result words.
interface dpdt_in_if import dpdt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [OFF_W-1:0]  offset;
    logic [DATA_W-1:0] write_data;

    modport source (output valid, action, offset, write_data, input ready);
    modport sink   (input valid, action, offset, write_data, output ready);
endinterface

interface dpdt_out_if import dpdt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              irq;
    logic              bad_access;

    modport source (output valid, read_data, irq, bad_access, input ready);
    modport sink   (input valid, read_data, irq, bad_access, output ready);
endinterface

FILE: hw/rtl/dpdt_chan.sv
// One timer channel: registers, prescaler, down-counter and interrupt flag.
module dpdt_chan import dpdt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_chan_cmd  i_cmd,
    output t_chan_stat o_stat
);

    logic [DATA_W-1:0] r_load,  n_load;
    logic [DATA_W-1:0] r_count, n_count;
    logic [CTRL_W-1:0] r_ctrl,  n_ctrl;
    logic [PRE_W-1:0]  r_pre,   n_pre;
    logic              r_flag,  n_flag;
    logic              r_pend,  n_pend;

    always_comb begin
        logic              wide;
        logic              hit;
        logic [DATA_W-1:0] old_v;
        logic [DATA_W-1:0] v;
        logic [DATA_W-1:0] v_test;

        n_load  = r_load;
        n_count = r_count;
        n_ctrl  = r_ctrl;
        n_pre   = r_pre;
        n_flag  = r_flag;
        n_pend  = r_pend;

        wide   = r_ctrl[CTL_SIZE32];
        old_v  = wide ? r_count : {{HALF_W{1'b0}}, r_count[HALF_W-1:0]};
        v      = old_v;
        v_test = old_v;
        hit    = 1'b0;

        if (i_cmd.wr_en) begin
            unique case (i_cmd.idx)
                REG_LOAD: begin
                    n_load = i_cmd.wdata;
                    n_pend = 1'b1;
                end
                REG_BGLOAD:  n_load = i_cmd.wdata;
                REG_CONTROL: n_ctrl = i_cmd.wdata[CTRL_W-1:0];
                REG_INTCLR:  n_flag = 1'b0;
                default: ;
            endcase
        end

        if (i_cmd.tick) begin
            // prescaler runs even while the channel is disabled
            n_pre = r_pre + PRE_W'(1);
            unique case (r_ctrl[CTL_PRE_HI:CTL_PRE_LO])
                PRE_DIV1:  hit = 1'b1;
                PRE_DIV16: hit = (n_pre[3:0] == 4'd0);
                default:   hit = (n_pre == '0);  // /256 and /4096 both wrap at 8 bits
            endcase
            if (r_ctrl[CTL_ENABLE]) begin
                if (r_pend) begin
                    n_pend = 1'b0;
                    v      = r_load;
                end else if (hit) begin
                    if (old_v == '0) begin
                        if (!r_ctrl[CTL_ONESHOT]) begin
                            v = r_ctrl[CTL_PERIODIC] ? r_load : COUNT_RESET;
                        end
                    end else begin
                        v = old_v - DATA_W'(1);
                    end
                end
                n_count = wide ? v : {r_count[DATA_W-1:HALF_W], v[HALF_W-1:0]};
                v_test  = wide ? v : {{HALF_W{1'b0}}, v[HALF_W-1:0]};
                if (old_v != '0 && v_test == '0) begin
                    n_flag = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load  <= '0;
            r_count <= COUNT_RESET;
            r_ctrl  <= CTRL_RESET;
            r_pre   <= '0;
            r_flag  <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            r_load  <= n_load;
            r_count <= n_count;
            r_ctrl  <= n_ctrl;
            r_pre   <= n_pre;
            r_flag  <= n_flag;
            r_pend  <= n_pend;
        end
    end

    // read from state before this word's update
    always_comb begin
        unique case (i_cmd.idx)
            REG_LOAD, REG_BGLOAD: o_stat.rdata = r_load;
            REG_VALUE:            o_stat.rdata = r_count;
            REG_CONTROL:          o_stat.rdata = {{(DATA_W-CTRL_W){1'b0}}, r_ctrl};
            REG_RIS:              o_stat.rdata = {{(DATA_W-1){1'b0}}, r_flag};
            REG_MIS:              o_stat.rdata = {{(DATA_W-1){1'b0}},
                                                  r_flag & r_ctrl[CTL_INTEN]};
            default:              o_stat.rdata = '0;
        endcase
        // interrupt level after this word
        o_stat.irq = n_flag & n_ctrl[CTL_INTEN];
    end

endmodule

FILE: hw/rtl/dual_prescaled_down_counter_timer.sv
// Dual prescaled down-counter timer: input stage, address decode, channels, result register.
//
// Usage:
//   i_in carries command words: action (read, write or tick), byte offset and
//   write data. Offset bit 5 selects the channel; bits 4:2 pick the register.
//   o_out carries one result word per command: read data (zero unless a
//   mapped read), the interrupt level after the command, and bad_access for
//   unmapped reads or writes.
//   A command is taken into an input register, executed against the channel
//   state once the output register is free, and its result loaded into the
//   output register, which offers it on o_out until it is taken.
//   Throughput is one command per cycle while o_out takes every result; each
//   command is a single decrement and decode step per channel.
//   When o_out stalls, the result register holds, the input register fills
//   behind it and i_in.ready drops only once both are occupied.
//   Synchronous reset clears both stages and puts every channel at load 0,
//   value all ones, control 0x20 and no pending interrupt; i_in.ready is low
//   during reset.
module dual_prescaled_down_counter_timer import dpdt_pkg::*; #(
    parameter int CHANNELS = 2
) (
    input logic        i_clk,
    input logic        i_rst_n,
    dpdt_in_if.sink    i_in,
    dpdt_out_if.source o_out
);

    logic              r_in_valid;
    logic [ACT_W-1:0]  r_in_action;
    logic [OFF_W-1:0]  r_in_offset;
    logic [DATA_W-1:0] r_in_wdata;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_rdata;
    logic              r_out_irq;
    logic              r_out_bad;

    logic out_free;
    logic adv;

    assign out_free   = !r_out_valid || o_out.ready;
    assign adv        = r_in_valid && out_free;
    assign i_in.ready = i_rst_n && (!r_in_valid || adv);

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_in_action <= i_in.action;
            r_in_offset <= i_in.offset;
            r_in_wdata  <= i_in.write_data;
        end
    end

    // address decode
    logic     ch;
    logic     chan_ok;
    logic     map_ok;
    t_reg_idx idx;
    logic     is_rd;
    logic     is_wr;
    logic     is_tick;
    logic     rd_bad;
    logic     wr_ignore;
    logic     wr_bad;
    logic     bad;

    assign ch        = r_in_offset[5];
    assign chan_ok   = !ch || (CHANNELS > 1);
    assign map_ok    = chan_ok && (r_in_offset[7:6] == 2'b00) && (r_in_offset[1:0] == 2'b00);
    assign idx       = r_in_offset[4:2];
    assign is_rd     = (r_in_action == ACT_READ);
    assign is_wr     = (r_in_action == ACT_WRITE);
    assign is_tick   = (r_in_action == ACT_TICK);
    assign rd_bad    = !map_ok || (idx == REG_INTCLR);
    assign wr_ignore = (r_in_offset == IGNORED_OFFSET);
    assign wr_bad    = !wr_ignore &&
                       (!map_ok || idx == REG_RIS || idx == REG_MIS || idx == REG_SPARE);
    assign bad       = (is_rd && rd_bad) || (is_wr && wr_bad);

    t_chan_cmd  chan_cmd  [CHANNELS];
    t_chan_stat chan_stat [CHANNELS];

    for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
        assign chan_cmd[g].wr_en = adv && is_wr && !wr_bad && !wr_ignore && (ch == 1'(g));
        assign chan_cmd[g].tick  = adv && is_tick;
        assign chan_cmd[g].idx   = idx;
        assign chan_cmd[g].wdata = r_in_wdata;

        dpdt_chan u_chan (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (chan_cmd[g]),
            .o_stat  (chan_stat[g])
        );
    end

    logic [DATA_W-1:0] sel_rdata;
    logic              irq_all;

    always_comb begin
        sel_rdata = '0;
        irq_all   = 1'b0;
        for (int g = 0; g < CHANNELS; g++) begin
            if (ch == 1'(g)) begin
                sel_rdata = chan_stat[g].rdata;
            end
            irq_all = irq_all | chan_stat[g].irq;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
        if (adv) begin
            r_out_rdata <= (is_rd && !rd_bad) ? sel_rdata : '0;
            r_out_irq   <= irq_all;
            r_out_bad   <= bad;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.read_data  = r_out_rdata;
    assign o_out.irq        = r_out_irq;
    assign o_out.bad_access = r_out_bad;

    a_bad_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_bad) |-> (r_out_rdata == '0))
        else $error("bad_access word carries nonzero read data");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_in_valid)
        else $error("accepted word missing from input stage");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !adv) |=>
            (r_in_valid && $stable(r_in_action) && $stable(r_in_offset)
             && $stable(r_in_wdata)))
        else $error("input stage changed while blocked");

    a_tick_not_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !is_rd && !is_wr) |=> !r_out_bad)
        else $error("bad_access raised for a non-bus word");

endmodule
